[rtl/shs_pkg.sv]
// ----------------------------------------------------------------------------
// shs_pkg
// Types, beat formats and constant tables shared by the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

    localparam int WORD_W = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int HASH_WORDS = 8;
    localparam int ROUNDS = 64;

    localparam logic [6:0] BLOCK_BYTES = 7'd64;
    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [2:0] MAX_BEAT_BYTES = 3'd4;
    localparam logic [2:0] LAST_DIGEST_IDX = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PACK,
        ST_PAD,
        ST_COMP,
        ST_OUT
    } shs_state_t;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic        last_word;
    } shs_msg_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_done;
    } shs_dig_t;

    typedef struct packed {
        logic start;
        logic reinit;
    } shs_rnd_ctrl_t;

    typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] shs_block_t;
    typedef logic [HASH_WORDS-1:0][WORD_W-1:0] shs_digest_t;

    localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

`default_nettype wire

[rtl/sha256_stream_hasher_top.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// Streaming SHA-256: byte packing, padding, block sequencing, digest output.
// ----------------------------------------------------------------------------
// Message beats carry up to four big-endian bytes each and are taken one per
// cycle while the current 64-byte block is filling. The beat that completes a
// block starts the shared round unit, which runs 64 rounds at one per cycle
// and then folds the result into the hash, so msg_stall stays high until it is
// done; bytes that spill past the block edge are then packed in ST_PACK.
// A last beat adds one padding step and one compression, or two of each when
// fewer than nine bytes of room remain. Eight digest beats then leave through
// a one-deep output register, word 0 first, with digest_done on word 7. Hash
// state returns to the initial values after that.
`default_nettype none

module sha256_stream_hasher_top
    import shs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     msg_valid,
    output logic          msg_stall,
    input  wire shs_msg_t msg_beat,
    output logic          hash_valid,
    input  wire logic     hash_stall,
    output shs_dig_t      hash_beat
);

    shs_state_t    state_reg;
    shs_state_t    state_next;

    logic [31:0]   buf_reg [BLOCK_WORDS];
    shs_block_t    buf_next;
    logic [5:0]    fill_reg;
    logic [31:0]   pend_data_reg;
    logic [2:0]    pend_cnt_reg;
    logic          last_reg;
    logic          final_reg;
    logic          pad2_reg;
    logic [60:0]   msg_reg;
    logic [2:0]    out_idx_reg;
    logic          out_valid_reg;
    shs_dig_t      out_reg;

    logic [2:0]    nb4;
    logic [31:0]   src_data;
    logic [2:0]    src_cnt;
    logic [6:0]    room;
    logic [2:0]    take;
    logic [6:0]    fill_sum;
    logic          full;
    logic [2:0]    rem_cnt;
    logic [31:0]   rem_data;
    logic          pad_final;
    logic [63:0]   len_bits;

    logic          do_pack;
    logic          do_pad;
    logic          out_load;
    logic          finish;
    logic          rnd_done;
    shs_rnd_ctrl_t rnd_ctrl;
    shs_digest_t   hash;

    function automatic logic [7:0] byte_sel(input logic [31:0] w, input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0: r = w[31:24];
            2'd1: r = w[23:16];
            2'd2: r = w[15:8];
            2'd3: r = w[7:0];
        endcase
        return r;
    endfunction

    // byte source: the arriving beat, or bytes left over past a block edge
    always_comb
    begin
        nb4      = (msg_beat.valid_bytes > MAX_BEAT_BYTES) ? MAX_BEAT_BYTES
                                                           : msg_beat.valid_bytes;
        src_data = (state_reg == ST_IDLE) ? msg_beat.data_word : pend_data_reg;
        src_cnt  = (state_reg == ST_IDLE) ? nb4 : pend_cnt_reg;
        room     = BLOCK_BYTES - {1'b0, fill_reg};
        take     = ({4'b0, src_cnt} > room) ? room[2:0] : src_cnt;
        fill_sum = {1'b0, fill_reg} + {4'b0, take};
        full     = fill_sum[6];
        rem_cnt  = src_cnt - take;
        unique case (take)
            3'd0:    rem_data = src_data;
            3'd1:    rem_data = {src_data[23:0], 8'b0};
            3'd2:    rem_data = {src_data[15:0], 16'b0};
            3'd3:    rem_data = {src_data[7:0], 24'b0};
            default: rem_data = '0;
        endcase
        pad_final = pad2_reg || (fill_reg < LEN_POS);
        len_bits  = {msg_reg, 3'b000};
    end

    always_comb
    begin
        logic [5:0] pos;
        logic [6:0] offs;
        for (int j = 0; j < BLOCK_WORDS; j++)
        begin
            buf_next[j] = buf_reg[j];
        end
        for (int j = 0; j < BLOCK_WORDS; j++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                pos  = 6'(4 * j + b);
                offs = {1'b0, pos} - {1'b0, fill_reg};
                if (do_pack)
                begin
                    if (!offs[6] && (offs < {4'b0, take}))
                    begin
                        buf_next[j][8*(3-b) +: 8] = byte_sel(src_data, offs[1:0]);
                    end
                end
                else if (do_pad)
                begin
                    if (!pad2_reg && (pos == fill_reg))
                    begin
                        buf_next[j][8*(3-b) +: 8] = PAD_BYTE;
                    end
                    else if (pad2_reg || (pos > fill_reg))
                    begin
                        buf_next[j][8*(3-b) +: 8] = '0;
                    end
                    // length field in the final block
                    if (pad_final && (pos >= LEN_POS))
                    begin
                        buf_next[j][8*(3-b) +: 8] = len_bits[8*(7-int'(pos[2:0])) +: 8];
                    end
                end
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    if (full)
                    begin
                        state_next = ST_COMP;
                    end
                    else if (msg_beat.last_word)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PACK:
            begin
                priority if (full)
                begin
                    state_next = ST_COMP;
                end
                else if (last_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                state_next = ST_COMP;
            end
            ST_COMP:
            begin
                if (rnd_done)
                begin
                    priority if (final_reg)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (pend_cnt_reg != 3'd0)
                    begin
                        state_next = ST_PACK;
                    end
                    else if (last_reg)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_load && (out_idx_reg == LAST_DIGEST_IDX))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        msg_stall = 1'b1;
        do_pack   = 1'b0;
        do_pad    = 1'b0;
        out_load  = 1'b0;
        finish    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                msg_stall = 1'b0;
                do_pack   = msg_valid;
            end
            ST_PACK:
            begin
                do_pack = 1'b1;
            end
            ST_PAD:
            begin
                do_pad = 1'b1;
            end
            ST_COMP:
            begin
                do_pack = 1'b0;
            end
            ST_OUT:
            begin
                out_load = !out_valid_reg || !hash_stall;
                finish   = out_load && (out_idx_reg == LAST_DIGEST_IDX);
            end
            default:
            begin
                msg_stall = 1'b1;
            end
        endcase
        rnd_ctrl.start  = (do_pack && full) || do_pad;
        rnd_ctrl.reinit = finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            pend_cnt_reg  <= '0;
            last_reg      <= 1'b0;
            final_reg     <= 1'b0;
            pad2_reg      <= 1'b0;
            msg_reg       <= '0;
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_pack)
            begin
                fill_reg     <= fill_sum[5:0];
                pend_cnt_reg <= rem_cnt;
                if (state_reg == ST_IDLE)
                begin
                    last_reg <= msg_beat.last_word;
                    msg_reg  <= msg_reg + 61'(nb4);
                end
            end
            if (do_pad)
            begin
                fill_reg <= '0;
                if (pad_final)
                begin
                    final_reg <= 1'b1;
                    pad2_reg  <= 1'b0;
                end
                else
                begin
                    pad2_reg <= 1'b1;
                end
            end
            // index wraps from word 7 back to word 0
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_idx_reg   <= out_idx_reg + 3'd1;
            end
            else if (!hash_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (finish)
            begin
                fill_reg  <= '0;
                last_reg  <= 1'b0;
                final_reg <= 1'b0;
                pad2_reg  <= 1'b0;
                msg_reg   <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < BLOCK_WORDS; j++)
        begin
            buf_reg[j] <= buf_next[j];
        end
        if (do_pack)
        begin
            pend_data_reg <= rem_data;
        end
        if (out_load)
        begin
            out_reg.digest_word <= hash[out_idx_reg];
            out_reg.word_index  <= out_idx_reg;
            out_reg.digest_done <= (out_idx_reg == LAST_DIGEST_IDX);
        end
    end

    shs_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rnd_ctrl),
        .blk   (buf_next),
        .done  (rnd_done),
        .hash  (hash)
    );

    assign hash_valid = out_valid_reg;
    assign hash_beat  = out_reg;

endmodule

`default_nettype wire

[rtl/shs_round.sv]
// ----------------------------------------------------------------------------
// shs_round
// SHA-256 compression unit: one round per cycle, then a final hash add.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_round
    import shs_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire shs_rnd_ctrl_t ctrl,
    input  wire shs_block_t    blk,
    output logic               done,
    output shs_digest_t        hash
);

    logic [31:0] win_reg [BLOCK_WORDS];
    logic [31:0] wv_reg [HASH_WORDS];
    logic [31:0] hash_reg [HASH_WORDS];
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        add_reg;

    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] k_cur;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    always_comb
    begin
        k_cur = ROUND_K[cnt_reg];
        // window holds W[t..t+15], so W[t+16] comes from fixed taps
        w_new = (rotr(win_reg[14], 17) ^ rotr(win_reg[14], 19) ^ (win_reg[14] >> 10))
              + win_reg[9]
              + (rotr(win_reg[1], 7) ^ rotr(win_reg[1], 18) ^ (win_reg[1] >> 3))
              + win_reg[0];
        t1 = wv_reg[7]
           + (rotr(wv_reg[4], 6) ^ rotr(wv_reg[4], 11) ^ rotr(wv_reg[4], 25))
           + ((wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]))
           + k_cur + win_reg[0];
        t2 = (rotr(wv_reg[0], 2) ^ rotr(wv_reg[0], 13) ^ rotr(wv_reg[0], 22))
           + ((wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            for (int i = 0; i < BLOCK_WORDS; i++)
            begin
                win_reg[i] <= blk[i];
            end
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                wv_reg[i] <= hash_reg[i];
            end
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[BLOCK_WORDS-1] <= w_new;
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= wv_reg[4];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            add_reg  <= 1'b0;
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                hash_reg[i] <= INIT_HASH[i];
            end
        end
        else
        begin
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == LAST_ROUND)
                begin
                    busy_reg <= 1'b0;
                    add_reg  <= 1'b1;
                end
            end
            else if (add_reg)
            begin
                add_reg <= 1'b0;
            end

            if (ctrl.reinit)
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    hash_reg[i] <= INIT_HASH[i];
                end
            end
            else if (add_reg)
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + wv_reg[i];
                end
            end
        end
    end

    assign done = add_reg;

    always_comb
    begin
        for (int i = 0; i < HASH_WORDS; i++)
        begin
            hash[i] = hash_reg[i];
        end
    end

endmodule

`default_nettype wire

[sim/tb_sha256_stream_hasher_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher_top
// Self-checking bench for the streaming SHA-256 hasher.
// ----------------------------------------------------------------------------
// A short table of directed message beats runs first: empty and "abc"
// messages with known digests, odd byte counts, ignored beats and a message
// that needs a second padding block. Random messages follow, many of them sized
// around the block boundary. Every accepted beat runs through a local SHA-256
// model, and each digest beat from the block is checked against the oldest
// queued word. Both sides idle at random in the first two of three phases.
// ----------------------------------------------------------------------------

module tb_sha256_stream_hasher_top;
    import shs_pkg::*;

    localparam int TARGET_BEATS = 430;

    localparam logic [31:0] RND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

    typedef struct {
        logic [31:0]  data;
        logic [2:0]   nbytes;
        logic         last;
        int           reps;
        bit           has_known;
        logic [255:0] known;
    } dir_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     msg_valid = 1'b0;
    logic     msg_stall;
    shs_msg_t msg_beat = '0;
    logic     hash_valid;
    logic     hash_stall = 1'b0;
    shs_dig_t hash_beat;

    int snd_idle_pct = 13;
    int rcv_idle_pct = 78;

    // local hash model state
    logic [31:0] run_hash [8];
    logic [31:0] blk_w [16];
    logic [5:0]  fill_cnt;
    logic [60:0] len_bytes;

    shs_dig_t digest_words_due [$];
    dir_row_t dir_tab [$];

    int beat_cnt = 0;
    int msg_cnt = 0;
    int digest_cnt = 0;
    int err_cnt = 0;

    sha256_stream_hasher_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg_valid  (msg_valid),
        .msg_stall  (msg_stall),
        .msg_beat   (msg_beat),
        .hash_valid (hash_valid),
        .hash_stall (hash_stall),
        .hash_beat  (hash_beat)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("timeout at %0t", $time);
        $display("FAILURE");
        $finish;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void sha_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] wt, x15, x2, t1, t2;
        w = blk_w;
        a = run_hash[0]; b = run_hash[1]; c = run_hash[2]; d = run_hash[3];
        e = run_hash[4]; f = run_hash[5]; g = run_hash[6]; h = run_hash[7];
        for (int r = 0; r < 64; r++)
        begin
            if (r < 16)
            begin
                wt = w[r];
            end
            else
            begin
                x15 = w[(r - 15) % 16];
                x2  = w[(r - 2) % 16];
                wt = w[r % 16] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
                   + w[(r - 7) % 16] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
                w[r % 16] = wt;
            end
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + RND_K[r] + wt;
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        run_hash[0] += a; run_hash[1] += b; run_hash[2] += c; run_hash[3] += d;
        run_hash[4] += e; run_hash[5] += f; run_hash[6] += g; run_hash[7] += h;
    endfunction

    function automatic void absorb_byte(input logic [7:0] v);
        blk_w[fill_cnt[5:2]][(3 - fill_cnt[1:0]) * 8 +: 8] = v;
        fill_cnt = fill_cnt + 6'd1;
        if (fill_cnt == 6'd0)
            sha_compress();
    endfunction

    function automatic void hash_restart();
        run_hash = SHA_IV;
        fill_cnt = '0;
        len_bytes = '0;
    endfunction

    // feed one beat to the model; a last beat queues its eight digest words
    function automatic void absorb_beat(input shs_msg_t m);
        int nb;
        logic [63:0] bit_len;
        shs_dig_t dw;
        nb = (m.valid_bytes > 3'd4) ? 4 : int'(m.valid_bytes);
        for (int i = 0; i < nb; i++)
            absorb_byte(m.data_word[31 - 8 * i -: 8]);
        len_bytes = len_bytes + 61'(nb);
        if (m.last_word)
        begin
            bit_len = {len_bytes, 3'b000};
            absorb_byte(8'h80);
            while (fill_cnt != 6'd56)
                absorb_byte(8'h00);
            for (int s = 56; s >= 0; s -= 8)
                absorb_byte(bit_len[s +: 8]);
            for (int i = 0; i < 8; i++)
            begin
                dw = '{run_hash[i], 3'(i), i == 7};
                digest_words_due.insert(digest_words_due.size(), dw);
            end
            hash_restart();
        end
    endfunction

    function automatic void add_row(input logic [31:0] data, input logic [2:0] nbytes,
                                    input logic last, input int reps,
                                    input bit has_known, input logic [255:0] known);
        dir_row_t row;
        row = '{data, nbytes, last, reps, has_known, known};
        dir_tab.insert(dir_tab.size(), row);
    endfunction

    // drive one beat from a falling edge and hold it until taken
    task automatic send_beat(input shs_msg_t m);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            msg_valid = 1'b0;
            @(negedge clk);
        end
        msg_valid = 1'b1;
        msg_beat = m;
        do
            @(posedge clk);
        while (msg_stall);
        absorb_beat(m);
        beat_cnt++;
        if (m.last_word)
            msg_cnt++;
        @(negedge clk);
    endtask

    task automatic send_random_msg();
        int nwords;
        int sel;
        shs_msg_t m;
        sel = $urandom_range(9);
        // bias lengths toward the 55/56/64 byte padding edges
        if (sel < 4)
            nwords = $urandom_range(17, 12);
        else if (sel < 9)
            nwords = $urandom_range(11, 0);
        else
            nwords = $urandom_range(48, 18);
        for (int k = 0; k < nwords; k++)
        begin
            sel = $urandom_range(19);
            m.data_word = $urandom;
            m.last_word = 1'b0;
            if (sel == 16)
                m.valid_bytes = 3'($urandom_range(7, 5));
            else if (sel == 17)
                m.valid_bytes = 3'($urandom_range(3, 1));
            else if (sel == 18)
                m.valid_bytes = 3'd0;
            else
                m.valid_bytes = MAX_BEAT_BYTES;
            send_beat(m);
        end
        m.data_word = $urandom;
        m.valid_bytes = 3'($urandom_range(7, 0));
        m.last_word = 1'b1;
        send_beat(m);
    endtask

    always @(negedge clk)
        hash_stall <= ($urandom_range(99) < rcv_idle_pct);

    always @(posedge clk)
    begin : digest_check
        shs_dig_t want;
        if (rst_n && hash_valid && !hash_stall)
        begin
            if (digest_words_due.size() == 0)
            begin
                $display("%0t: unexpected digest beat: actual %h", $time, hash_beat);
                err_cnt++;
            end
            else
            begin
                want = digest_words_due.pop_front();
                digest_cnt++;
                if (hash_beat.digest_word !== want.digest_word)
                begin
                    $display("%0t: digest_word mismatch: expected %h, actual %h",
                             $time, want.digest_word, hash_beat.digest_word);
                    err_cnt++;
                end
                if (hash_beat.word_index !== want.word_index)
                begin
                    $display("%0t: word_index mismatch: expected %0d, actual %0d",
                             $time, want.word_index, hash_beat.word_index);
                    err_cnt++;
                end
                if (hash_beat.digest_done !== want.digest_done)
                begin
                    $display("%0t: digest_done mismatch: expected %b, actual %b",
                             $time, want.digest_done, hash_beat.digest_done);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin : stimulus
        shs_msg_t m;
        int wait_cnt;
        shs_dig_t kw;
        hash_restart();
        blk_w = '{default: '0};

        add_row(32'h0000_0000, 3'd0, 1'b1, 1, 1'b1, EMPTY_DIGEST);
        add_row(32'h6162_6300, 3'd3, 1'b1, 1, 1'b1, ABC_DIGEST);
        // counts above four act as four; zero-count non-last beats are dropped
        add_row(32'hffff_ffff, 3'd7, 1'b0, 1, 1'b0, '0);
        add_row(32'hdead_beef, 3'd0, 1'b0, 1, 1'b0, '0);
        // short non-last beats pack bytewise with no realignment
        add_row(32'ha5c3_3c5a, 3'd1, 1'b0, 1, 1'b0, '0);
        add_row(32'h0123_4567, 3'd2, 1'b0, 1, 1'b0, '0);
        add_row(32'h89ab_cdef, 3'd3, 1'b0, 1, 1'b0, '0);
        add_row(32'h7f80_01fe, 3'd5, 1'b0, 1, 1'b0, '0);
        add_row(32'h5555_aaaa, 3'd6, 1'b0, 1, 1'b0, '0);
        add_row(32'h0000_0000, 3'd4, 1'b1, 1, 1'b0, '0);
        // 56 bytes then an empty last beat: padding spills into a second block
        add_row(32'hffff_ffff, 3'd4, 1'b0, 14, 1'b0, '0);
        add_row(32'hffff_ffff, 3'd0, 1'b1, 1, 1'b0, '0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
        begin
            m = '{dir_tab[i].data, dir_tab[i].nbytes, dir_tab[i].last};
            for (int r = 0; r < dir_tab[i].reps; r++)
                send_beat(m);
            if (dir_tab[i].has_known)
            begin
                repeat (8) digest_words_due.delete(digest_words_due.size() - 1);
                for (int k = 0; k < 8; k++)
                begin
                    kw = '{dir_tab[i].known[255 - 32 * k -: 32], 3'(k), k == 7};
                    digest_words_due.insert(digest_words_due.size(), kw);
                end
            end
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1)
            begin
                snd_idle_pct = 78;
                rcv_idle_pct = 13;
            end
            else if (ph == 2)
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            while (beat_cnt < (ph + 1) * TARGET_BEATS / 3)
                send_random_msg();
        end
        msg_valid = 1'b0;

        wait_cnt = 0;
        while (digest_words_due.size() != 0 && wait_cnt < 200000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        if (digest_words_due.size() != 0)
        begin
            $display("%0t: %0d digest words never arrived", $time,
                     digest_words_due.size());
            err_cnt++;
        end
        repeat (150) @(posedge clk);

        $display("run covered %0d messages in %0d beats, %0d digest beats checked",
                 msg_cnt, beat_cnt, digest_cnt);
        $display("mismatches seen: %0d", err_cnt);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
rtl/shs_pkg.sv
rtl/shs_round.sv
rtl/sha256_stream_hasher_top.sv
sim/tb_sha256_stream_hasher_top.sv
